// ===== rtl/core/ipv4fl_pkg.sv =====
// Package for the IPv4 forwarding lookup block: sizes, codes and the
// token types that travel along the route and neighbour cell chains.
// No dependencies.
package ipv4fl_pkg;

	localparam int ROUTE_DEPTH    = 128;
	localparam int NEIGHBOR_DEPTH = 128;
	localparam int PORT_BITS      = 4;
	localparam int COUNT_W        = 8;
	localparam int SLOT_W         = 7;
	localparam int POS_W          = 8;

	typedef enum logic [1:0] {
		OP_WR_ROUTE = 2'd0,
		OP_WR_NBR   = 2'd1,
		OP_FORWARD  = 2'd2,
		OP_UNUSED   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		V_FORWARD  = 3'd0,
		V_NO_ROUTE = 3'd1,
		V_TTL      = 3'd2,
		V_NO_MAC   = 3'd3,
		V_WRITE    = 3'd4
	} verdict_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUTE,
		ST_NBR,
		ST_HOLD
	} state_t;

	// token moving down the route chain: a write or a lookup
	typedef struct packed {
		logic                 valid;
		logic                 wr;
		logic [SLOT_W-1:0]    slot;
		logic [POS_W-1:0]     pos;
		logic [31:0]          addr;
		logic [31:0]          mask;
		logic [31:0]          gw;
		logic [PORT_BITS-1:0] port;
		logic                 found;
		logic [31:0]          top_mask;
		logic [31:0]          best_gw;
		logic [PORT_BITS-1:0] best_port;
	} rt_tok_t;

	// token moving down the neighbour chain
	typedef struct packed {
		logic              valid;
		logic              wr;
		logic [SLOT_W-1:0] slot;
		logic [POS_W-1:0]  pos;
		logic [31:0]       ip;
		logic [47:0]       mac;
		logic              done;
	} nb_tok_t;

endpackage

// ===== rtl/core/ipv4fl_route_cell.sv =====
// One route table entry and its compare stage in the route chain.
// Depends on ipv4fl_pkg.
module ipv4fl_route_cell (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [ipv4fl_pkg::COUNT_W-1:0]       count,
	input  ipv4fl_pkg::rt_tok_t                  tin,
	output ipv4fl_pkg::rt_tok_t                  tout
);
	logic [31:0]                      prefix_q;
	logic [31:0]                      mask_q;
	logic [31:0]                      gw_q;
	logic [ipv4fl_pkg::PORT_BITS-1:0] port_q;
	logic                             valid_q;
	ipv4fl_pkg::rt_tok_t              tok_q;
	ipv4fl_pkg::rt_tok_t              tok_d;
	logic                             mine;
	logic                             hit;

	assign mine = tin.valid && tin.wr && (tin.pos == {1'b0, tin.slot});
	// later entry wins a tie on the mask
	assign hit = tin.valid && !tin.wr && (tin.pos < count)
		&& ((mask_q & tin.addr) == prefix_q) && (mask_q >= tin.top_mask);

	always_ff @(posedge clk) begin
		if (mine) begin
			prefix_q <= tin.addr;
			mask_q   <= tin.mask;
			gw_q     <= tin.gw;
			port_q   <= tin.port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tin.valid;
		end
	end

	always_comb begin
		tok_d     = tin;
		tok_d.pos = tin.pos + 1'b1;
		if (hit) begin
			tok_d.found     = 1'b1;
			tok_d.top_mask  = mask_q;
			tok_d.best_gw   = gw_q;
			tok_d.best_port = port_q;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
	end

	always_comb begin
		tout       = tok_q;
		tout.valid = valid_q;
	end
endmodule

// ===== rtl/core/ipv4fl_nbr_cell.sv =====
// One neighbour table entry and its compare stage in the neighbour chain.
// Depends on ipv4fl_pkg.
module ipv4fl_nbr_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [ipv4fl_pkg::COUNT_W-1:0] count,
	input  ipv4fl_pkg::nb_tok_t            tin,
	output ipv4fl_pkg::nb_tok_t            tout
);
	logic [31:0]         ip_q;
	logic [47:0]         mac_q;
	logic                valid_q;
	ipv4fl_pkg::nb_tok_t tok_q;
	ipv4fl_pkg::nb_tok_t tok_d;
	logic                mine;
	logic                hit;

	assign mine = tin.valid && tin.wr && (tin.pos == {1'b0, tin.slot});
	// first match wins: once done, hold
	assign hit = tin.valid && !tin.wr && !tin.done && (tin.pos < count)
		&& (ip_q == tin.ip);

	always_ff @(posedge clk) begin
		if (mine) begin
			ip_q  <= tin.ip;
			mac_q <= tin.mac;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tin.valid;
		end
	end

	always_comb begin
		tok_d     = tin;
		tok_d.pos = tin.pos + 1'b1;
		if (hit) begin
			tok_d.done = 1'b1;
			tok_d.mac  = mac_q;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
	end

	always_comb begin
		tout       = tok_q;
		tout.valid = valid_q;
	end
endmodule

// ===== rtl/core/ipv4_forward_lookup.sv =====
// Top level of the IPv4 forwarding lookup: control, result register and
// the route and neighbour cell chains. Depends on ipv4fl_pkg and the cells.
//
//  channel  dir  handshake        payload
//  s_axis   in   tvalid/tready    tuser: operation; tdata: see port
//  m_axis   out  tvalid/tready    tuser: verdict;   tdata: see port
//  cfg      in   cfg_we           cfg_index, cfg_wdata
//
// One item at a time. A route write sends its token down the route chain, a
// neighbour write down the neighbour chain, a lookup down the route chain and,
// on a route hit with ttl above 1, the neighbour chain, one cell per cycle.
// Operation 3 answers with no scan. Reset clears control only; table contents
// are undefined until written. The input is not taken while a result waits.
module ipv4_forward_lookup (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// slot[6:0] address[38:7] prefix_mask[70:39] gateway[102:71]
	// port[106:103] hardware_address[154:107] ttl_in[162:155], zero fill
	input  logic [167:0] s_tdata,
	// operation[1:0]
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_port[3:0] dest_mac[51:4] ttl_out[59:52] hop_address[91:60], zero fill
	output logic [95:0]  m_tdata,
	// verdict[2:0]
	output logic [2:0]   m_tuser,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [7:0]   cfg_wdata
);
	ipv4fl_pkg::state_t   state_q, state_d;
	logic [7:0]           route_count_q, neighbor_count_q;
	logic [7:0]           ttl_q;
	logic [3:0]           port_q;
	logic [31:0]          hop_q;
	logic [2:0]           verdict_q;
	logic [3:0]           oport_q;
	logic [47:0]          mac_q;
	logic [7:0]           ttlo_q;
	logic [31:0]          hopo_q;
	logic                 s_acc;
	logic                 load;
	logic [2:0]           v_d;
	logic [3:0]           p_d;
	logic [47:0]          m_d;
	logic [7:0]           t_d;
	logic [31:0]          h_d;
	ipv4fl_pkg::op_t      op;
	ipv4fl_pkg::rt_tok_t  rt_link [0:ipv4fl_pkg::ROUTE_DEPTH];
	ipv4fl_pkg::nb_tok_t  nb_link [0:ipv4fl_pkg::NEIGHBOR_DEPTH];
	ipv4fl_pkg::rt_tok_t  rt_head;
	ipv4fl_pkg::nb_tok_t  nb_head;
	ipv4fl_pkg::rt_tok_t  rt_end;
	ipv4fl_pkg::nb_tok_t  nb_end;

	assign op         = ipv4fl_pkg::op_t'(s_tuser);
	assign s_tready   = (state_q == ipv4fl_pkg::ST_IDLE);
	assign s_acc      = s_tvalid && s_tready;
	assign rt_link[0] = rt_head;
	assign nb_link[0] = nb_head;
	assign rt_end     = rt_link[ipv4fl_pkg::ROUTE_DEPTH];
	assign nb_end     = nb_link[ipv4fl_pkg::NEIGHBOR_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_count_q    <= '0;
			neighbor_count_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) begin
				route_count_q <= cfg_wdata;
			end else begin
				neighbor_count_q <= cfg_wdata;
			end
		end
	end

	// inject into the route chain
	always_comb begin
		rt_head           = '0;
		rt_head.valid     = s_acc && (op == ipv4fl_pkg::OP_WR_ROUTE
			|| op == ipv4fl_pkg::OP_FORWARD);
		rt_head.wr        = (op == ipv4fl_pkg::OP_WR_ROUTE);
		rt_head.slot      = s_tdata[6:0];
		rt_head.addr      = s_tdata[38:7];
		rt_head.mask      = s_tdata[70:39];
		rt_head.gw        = s_tdata[102:71];
		rt_head.port      = s_tdata[106:103];
	end

	// inject into the neighbour chain: a write, or the next hop of a lookup
	always_comb begin
		nb_head       = '0;
		if (s_acc && op == ipv4fl_pkg::OP_WR_NBR) begin
			nb_head.valid = 1'b1;
			nb_head.wr    = 1'b1;
			nb_head.slot  = s_tdata[6:0];
			nb_head.ip    = s_tdata[38:7];
			nb_head.mac   = s_tdata[154:107];
		end else if (rt_end.valid && !rt_end.wr && rt_end.found && ttl_q > 8'd1) begin
			nb_head.valid = 1'b1;
			nb_head.ip    = rt_end.best_gw;
		end
	end

	for (genvar i = 0; i < ipv4fl_pkg::ROUTE_DEPTH; i++) begin : g_rt
		ipv4fl_route_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.count  (route_count_q),
			.tin    (rt_link[i]),
			.tout   (rt_link[i+1])
		);
	end

	for (genvar j = 0; j < ipv4fl_pkg::NEIGHBOR_DEPTH; j++) begin : g_nb
		ipv4fl_nbr_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.count  (neighbor_count_q),
			.tin    (nb_link[j]),
			.tout   (nb_link[j+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ipv4fl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		v_d     = ipv4fl_pkg::V_WRITE;
		p_d     = '0;
		m_d     = '0;
		t_d     = '0;
		h_d     = '0;
		unique case (state_q)
			ipv4fl_pkg::ST_IDLE: begin
				if (s_acc) begin
					unique case (op)
						ipv4fl_pkg::OP_WR_ROUTE, ipv4fl_pkg::OP_FORWARD:
							state_d = ipv4fl_pkg::ST_ROUTE;
						ipv4fl_pkg::OP_WR_NBR: state_d = ipv4fl_pkg::ST_NBR;
						default: begin
							load    = 1'b1;
							state_d = ipv4fl_pkg::ST_HOLD;
						end
					endcase
				end
			end
			ipv4fl_pkg::ST_ROUTE: begin
				if (rt_end.valid) begin
					if (rt_end.wr) begin
						load    = 1'b1;
						state_d = ipv4fl_pkg::ST_HOLD;
					end else if (!rt_end.found) begin
						load    = 1'b1;
						v_d     = ipv4fl_pkg::V_NO_ROUTE;
						state_d = ipv4fl_pkg::ST_HOLD;
					end else if (ttl_q <= 8'd1) begin
						load    = 1'b1;
						v_d     = ipv4fl_pkg::V_TTL;
						h_d     = rt_end.best_gw;
						state_d = ipv4fl_pkg::ST_HOLD;
					end else begin
						state_d = ipv4fl_pkg::ST_NBR;
					end
				end
			end
			ipv4fl_pkg::ST_NBR: begin
				if (nb_end.valid) begin
					load    = 1'b1;
					state_d = ipv4fl_pkg::ST_HOLD;
					if (!nb_end.wr) begin
						h_d = hop_q;
						if (nb_end.done) begin
							v_d = ipv4fl_pkg::V_FORWARD;
							p_d = port_q;
							m_d = nb_end.mac;
							t_d = ttl_q - 8'd1;
						end else begin
							v_d = ipv4fl_pkg::V_NO_MAC;
						end
					end
				end
			end
			ipv4fl_pkg::ST_HOLD: begin
				if (m_tready) begin
					state_d = ipv4fl_pkg::ST_IDLE;
				end
			end
			default: state_d = ipv4fl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			ttl_q <= s_tdata[162:155];
		end
		if (state_q == ipv4fl_pkg::ST_ROUTE && rt_end.valid) begin
			hop_q  <= rt_end.best_gw;
			port_q <= rt_end.best_port;
		end
		if (load) begin
			verdict_q <= v_d;
			oport_q   <= p_d;
			mac_q     <= m_d;
			ttlo_q    <= t_d;
			hopo_q    <= h_d;
		end
	end

	assign m_tvalid = (state_q == ipv4fl_pkg::ST_HOLD);
	assign m_tuser  = verdict_q;
	assign m_tdata  = {4'd0, hopo_q, ttlo_q, mac_q, oport_q};

	a_rt_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rt_end.valid |-> state_q == ipv4fl_pkg::ST_ROUTE)
		else $error("route token left chain outside route scan");
	a_nb_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		nb_end.valid |-> state_q == ipv4fl_pkg::ST_NBR)
		else $error("neighbour token left chain outside neighbour scan");
	a_fwd_ttl: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ipv4fl_pkg::V_FORWARD) |-> m_tdata[59:52] != 8'd0)
		else $error("forwarded with zero ttl");
	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ipv4fl_pkg::V_WRITE) |-> m_tdata == 96'd0)
		else $error("write result carries data");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata) && m_tvalid)
		else $error("result changed while stalled");
endmodule
